### hw/rtl/sequent_peak_storage_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// sequent peak storage tracker assertion macros
// shared helpers for concurrent checks in the tracker rtl
// ----------------------------------------------------------------------------
`ifndef SEQUENT_PEAK_STORAGE_TRACKER_UNIT_DEFINES_SVH
`define SEQUENT_PEAK_STORAGE_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SPST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define SPST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/spst_pkg.sv
// ----------------------------------------------------------------------------
// spst_pkg
// widths, register map and shared types of the peak storage tracker
// ----------------------------------------------------------------------------
`default_nettype none

package spst_pkg;

  localparam int CELLS_DEF = 4096;
  localparam int CELL_W    = 12;
  localparam int SAMPLE_W  = 32;
  localparam int STORE_W   = 40;
  localparam int DELTA_W   = SAMPLE_W + 1;
  localparam int SUM_W     = STORE_W + 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam logic [STORE_W-1:0]  STORE_MAX    = {STORE_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] MISSING_DEF  = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_TRG_MISS   = 2'd1,
    REG_SRC_MISS   = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                mode_deficit;
    logic [SAMPLE_W-1:0] target_missing_code;
    logic [SAMPLE_W-1:0] source_missing_code;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/spst_ram.sv
// ----------------------------------------------------------------------------
// spst_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module spst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spst_cfg.sv
// ----------------------------------------------------------------------------
// spst_cfg
// apb register file: mode and the two missing-sample codes
// ----------------------------------------------------------------------------
`default_nettype none

module spst_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spst_pkg::APB_AW-1:0]  paddr,
  input  wire logic [spst_pkg::APB_DW-1:0]  pwdata,
  output logic      [spst_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output spst_pkg::cfg_t                    cfg
);

  spst_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = spst_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_deficit        <= 1'b1;
      cfg.target_missing_code <= spst_pkg::MISSING_DEF;
      cfg.source_missing_code <= spst_pkg::MISSING_DEF;
    end else if (wr) begin
      case (idx)
        spst_pkg::REG_MODE:     cfg.mode_deficit        <= pwdata[0];
        spst_pkg::REG_TRG_MISS: cfg.target_missing_code <= pwdata;
        spst_pkg::REG_SRC_MISS: cfg.source_missing_code <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spst_pkg::REG_MODE:     prdata = {{(spst_pkg::APB_DW-1){1'b0}}, cfg.mode_deficit};
      spst_pkg::REG_TRG_MISS: prdata = cfg.target_missing_code;
      spst_pkg::REG_SRC_MISS: prdata = cfg.source_missing_code;
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/spst_update.sv
// ----------------------------------------------------------------------------
// spst_update
// one cell step: range and missing checks, signed delta, clamp and saturate, peak raise
// ----------------------------------------------------------------------------
`default_nettype none

module spst_update (
  input  wire spst_pkg::cfg_t                     cfg,
  input  wire logic                               oor,
  input  wire logic [spst_pkg::SAMPLE_W-1:0]      trg,
  input  wire logic [spst_pkg::SAMPLE_W-1:0]      src,
  input  wire logic [spst_pkg::STORE_W-1:0]       base_now,
  input  wire logic [spst_pkg::STORE_W-1:0]       base_peak,
  output logic      [spst_pkg::STORE_W-1:0]       res_now,
  output logic      [spst_pkg::STORE_W-1:0]       res_peak,
  output logic                                    res_skip
);

  logic                              miss;
  logic [spst_pkg::DELTA_W-1:0]      trg_x;
  logic [spst_pkg::DELTA_W-1:0]      src_x;
  logic [spst_pkg::DELTA_W-1:0]      delta;
  logic [spst_pkg::SUM_W-1:0]        sum;
  logic [spst_pkg::STORE_W-1:0]      now;

  assign miss  = (trg == cfg.target_missing_code) || (src == cfg.source_missing_code);
  assign trg_x = {trg[spst_pkg::SAMPLE_W-1], trg};
  assign src_x = {src[spst_pkg::SAMPLE_W-1], src};
  assign delta = cfg.mode_deficit ? (trg_x - src_x) : (src_x - trg_x);
  assign sum   = {2'b00, base_now}
               + {{(spst_pkg::SUM_W-spst_pkg::DELTA_W){delta[spst_pkg::DELTA_W-1]}}, delta};

  always_comb begin
    // top bit is the sign, the next one flags a carry past the store width
    if (sum[spst_pkg::SUM_W-1]) begin
      now = '0;
    end else if (sum[spst_pkg::SUM_W-2]) begin
      now = spst_pkg::STORE_MAX;
    end else begin
      now = sum[spst_pkg::STORE_W-1:0];
    end

    if (oor) begin
      res_now  = '0;
      res_peak = '0;
      res_skip = 1'b1;
    end else if (miss) begin
      res_now  = base_now;
      res_peak = base_peak;
      res_skip = 1'b1;
    end else begin
      res_now  = now;
      res_peak = (now > base_peak) ? now : base_peak;
      res_skip = 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sequent_peak_storage_tracker_unit.sv
// ----------------------------------------------------------------------------
// sequent_peak_storage_tracker_unit: per-cell running and peak storage tracker
// path: a taken item waits in stage 1 for its ram read, then moves on to the output register
// throughput: one item per cycle unless clearing or stalled by m_tready; one ram write port, one-entry forward
// reset: config returns to defaults, then a clearing pass over every cell zeroes the ram
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequent_peak_storage_tracker_unit_defines.svh"

module sequent_peak_storage_tracker_unit #(
  parameter int CELLS = spst_pkg::CELLS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // config port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spst_pkg::APB_AW-1:0]  paddr,
  input  wire logic [spst_pkg::APB_DW-1:0]  pwdata,
  output logic      [spst_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  // input items
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [79:0]                  s_tdata,  // cell_req, target_sample, source_sample, pad
  // result items
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [95:0]                  m_tdata,  // cell_out, storage_now, storage_peak, pad
  output logic      [0:0]                   m_tuser   // skipped
);

  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW     = spst_pkg::CELL_W;
  localparam int SW     = spst_pkg::SAMPLE_W;
  localparam int STW    = spst_pkg::STORE_W;
  localparam int RAM_W  = 2 * STW;

  spst_pkg::cfg_t cfg;

  // clearing pass state
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // stage 1: taken item, ram read is in flight for its cell
  logic              s1_valid;
  logic [CW-1:0]     s1_cell;
  logic [SW-1:0]     s1_trg;
  logic [SW-1:0]     s1_src;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_oor;
  logic              s1_adv;
  logic              s_acc;

  // last ram write, covers the read that lands on the same edge
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [RAM_W-1:0]  fwd_data;
  logic              fwd_hit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic [RAM_W-1:0]  base;

  logic [STW-1:0]    res_now;
  logic [STW-1:0]    res_peak;
  logic              res_skip;

  // result register payload
  logic [CW-1:0]     out_cell;
  logic [STW-1:0]    out_now;
  logic [STW-1:0]    out_peak;
  logic              out_skip;

  spst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: stage 1 moves on whenever the result register is free or being drained
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign s_acc    = s_tvalid && s_tready;

  assign s1_addr  = ADDR_W'(s1_cell);
  assign s1_oor   = 32'(s1_cell) >= 32'(CELLS);

  // ram holds {peak, now} for every cell
  assign ram_we    = clearing || (s1_adv && !s1_oor);
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : {res_peak, res_now};

  spst_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s_acc),
    .raddr (ADDR_W'(s_tdata[CW-1:0])),
    .rdata (ram_rdata)
  );

  // on an address match the last ram write wins, as it may have landed on the edge this item was read
  assign fwd_hit = fwd_valid && (fwd_addr == s1_addr);
  assign base    = fwd_hit ? fwd_data : ram_rdata;

  spst_update u_update (
    .cfg       (cfg),
    .oor       (s1_oor),
    .trg       (s1_trg),
    .src       (s1_src),
    .base_now  (base[STW-1:0]),
    .base_peak (base[RAM_W-1:STW]),
    .res_now   (res_now),
    .res_peak  (res_peak),
    .res_skip  (res_skip)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end

      if (s_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv && !s1_oor) begin
        fwd_valid <= 1'b1;
      end

      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_cell <= s_tdata[CW-1:0];
      s1_trg  <= s_tdata[CW+SW-1:CW];
      s1_src  <= s_tdata[CW+2*SW-1:CW+SW];
    end
    if (s1_adv && !s1_oor) begin
      fwd_addr <= s1_addr;
      fwd_data <= {res_peak, res_now};
    end
    if (s1_adv) begin
      out_cell <= s1_cell;
      out_now  <= res_now;
      out_peak <= res_peak;
      out_skip <= res_skip;
    end
  end

  assign m_tdata = {{(96-CW-2*STW){1'b0}}, out_peak, out_now, out_cell};
  assign m_tuser = out_skip;

  // no item is taken until the ram has been swept
  `SPST_ASSERT_IMP(a_no_take_clearing, clk, rst, clearing, !s_tready, "item taken during clear")
  // the clearing pass runs once after reset and never restarts
  `SPST_ASSERT_NXT(a_clear_once, clk, rst, !clearing, !clearing, "clearing pass restarted")
  // an updated result never reports storage above its peak
  `SPST_ASSERT_IMP(a_now_le_peak, clk, rst, m_tvalid && !m_tuser[0],
    out_now <= out_peak, "storage above peak")
  // a cell outside the store always reports as skipped
  `SPST_ASSERT_NXT(a_oor_skip, clk, rst, s1_adv && s1_oor,
    m_tvalid && m_tuser[0], "out of range cell not skipped")

endmodule

`default_nettype wire

### tb/sv/sequent_peak_storage_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequent_peak_storage_tracker_unit_tb
// self-checking bench for the per-cell running and peak storage tracker.
// items go in on the slave stream and results come back on the master stream.
// a behavioural tracker in the bench predicts each result, and results are
// checked field by field in order. directed tests cover both accumulation
// modes, the missing-sample codes, clamping at zero and saturation. random
// traffic with hot cells and random stalls on both streams follows.
// ----------------------------------------------------------------------------

module sequent_peak_storage_tracker_unit_tb;
  import spst_pkg::*;

  // expected result of one item, fields as they appear on the master stream
  typedef struct packed {
    logic [CELL_W-1:0]  cell_no;
    logic [STORE_W-1:0] now;
    logic [STORE_W-1:0] peak;
    logic               skipped;
  } tracker_result_t;

  localparam int ITEMS_PER_PHASE = 363;

  // clock, reset and block ports
  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_tvalid;
  logic                s_tready;
  logic [79:0]         s_tdata;   // cell_req, target_sample, source_sample, pad
  logic                m_tvalid;
  logic                m_tready;
  logic [95:0]         m_tdata;   // cell_out, storage_now, storage_peak, pad
  logic [0:0]          m_tuser;   // skipped

  // bench copy of the tracker: configuration and both per-cell stores
  cfg_t                tracker_cfg;
  logic [STORE_W-1:0]  running_level [CELLS_DEF];
  logic [STORE_W-1:0]  peak_level    [CELLS_DEF];

  tracker_result_t     pending_results [$];
  int                  mismatch_count = 0;
  bit                  idle_enable = 1'b1;   // random gaps on both streams
  int                  hot_cells [8];

  sequent_peak_storage_tracker_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // apply one item to the bench tracker and return the result it should give
  function automatic tracker_result_t apply_sample(logic [CELL_W-1:0] cell_idx,
                                                   logic [SAMPLE_W-1:0] trg,
                                                   logic [SAMPLE_W-1:0] src);
    tracker_result_t    res;
    longint             delta;
    longint             total;
    logic [STORE_W-1:0] level;
    res.cell_no = cell_idx;
    if (int'(cell_idx) >= CELLS_DEF) begin
      // cell beyond the store: nothing touched, zeros reported
      res.now     = '0;
      res.peak    = '0;
      res.skipped = 1'b1;
      return res;
    end
    if (trg == tracker_cfg.target_missing_code ||
        src == tracker_cfg.source_missing_code) begin
      // missing sample: report the cell as it stands
      res.now     = running_level[cell_idx];
      res.peak    = peak_level[cell_idx];
      res.skipped = 1'b1;
      return res;
    end
    if (tracker_cfg.mode_deficit)
      delta = longint'($signed(trg)) - longint'($signed(src));
    else
      delta = longint'($signed(src)) - longint'($signed(trg));
    total = longint'(running_level[cell_idx]) + delta;
    // clamp at zero below, saturate at the store maximum above
    if (total < 0)
      level = '0;
    else if (total > longint'(STORE_MAX))
      level = STORE_MAX;
    else
      level = total[STORE_W-1:0];
    running_level[cell_idx] = level;
    if (level > peak_level[cell_idx])
      peak_level[cell_idx] = level;
    res.now     = level;
    res.peak    = peak_level[cell_idx];
    res.skipped = 1'b0;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // every accepted result is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    tracker_result_t want;
    tracker_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.cell_no = m_tdata[CELL_W-1:0];
      got.now     = m_tdata[CELL_W +: STORE_W];
      got.peak    = m_tdata[CELL_W+STORE_W +: STORE_W];
      got.skipped = m_tuser[0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, cell", got.cell_no, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.cell_no !== want.cell_no)
          report_mismatch("cell_out", got.cell_no, want.cell_no);
        if (got.now !== want.now)
          report_mismatch("storage_now", got.now, want.now);
        if (got.peak !== want.peak)
          report_mismatch("storage_peak", got.peak, want.peak);
        if (got.skipped !== want.skipped)
          report_mismatch("skipped", got.skipped, want.skipped);
      end
    end
  end

  // ------------------------------------------------------------------------
  // pacing of both streams
  // ------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (!idle_enable)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65)
      return 0;
    else if (roll < 95)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // result side back-pressure, one assignment per edge
  always @(posedge clk) begin : sink_pacing
    int stall_left;
    if (rst) begin
      stall_left = 0;
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stream and register access
  // ------------------------------------------------------------------------

  // offer one item after a random gap and predict it once it is taken
  task automatic send_item(logic [CELL_W-1:0] cell_idx, logic [SAMPLE_W-1:0] trg,
                           logic [SAMPLE_W-1:0] src);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, src, trg, cell_idx};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_sample(cell_idx, trg, src));
  endtask

  // stop offering items and let every outstanding result come back
  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    // a margin after the last result comes back
    repeat (4) @(posedge clk);
  endtask

  // two-phase register write, only with the block idle
  task automatic write_register(reg_idx_t idx, logic [APB_DW-1:0] value);
    wait_until_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:     tracker_cfg.mode_deficit        = value[0];
      REG_TRG_MISS: tracker_cfg.target_missing_code = value;
      REG_SRC_MISS: tracker_cfg.source_missing_code = value;
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset configuration: deficit mode, both codes at the most negative value
  task automatic test_deficit_directed();
    send_item(12'd0,   32'h7FFF_FFFF, 32'h8000_0001);   // largest rise
    send_item(12'd0,   32'h8000_0001, 32'h7FFF_FFFF);   // drains exactly to zero
    send_item(12'd0,   32'h8000_0000, 32'h0000_0000);   // target missing
    send_item(12'd0,   32'h0000_0000, 32'h8000_0000);   // source missing
    send_item(12'd0,   32'h8000_0000, 32'h8000_0000);   // both missing
    send_item(12'd4095, 32'h0001_0000, 32'h0000_0000);  // plus one
    send_item(12'd4095, 32'h0001_0000, 32'h0001_0000);  // no change
    send_item(12'd4095, 32'hFFFF_FFFF, 32'h0000_0000);  // tiny step down, peak kept
    send_item(12'hAAA, 32'hFFFF_FFFF, 32'h0000_0000);   // negative from empty
    send_item(12'h555, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // surplus mode, written with every other bit set to show only bit 0 counts
  task automatic test_surplus_directed();
    write_register(REG_MODE, 32'hFFFF_FFFE);
    send_item(12'd1,    32'h8000_0001, 32'h7FFF_FFFF);  // rises in surplus mode
    send_item(12'd1,    32'h7FFF_FFFF, 32'h8000_0001);  // drains exactly to zero
    send_item(12'd4095, 32'h0000_0000, 32'h0000_8000);  // adds one half
    send_item(12'd4095, 32'h0001_0000, 32'h0000_0000);
  endtask

  // missing codes moved away from their reset values
  task automatic test_missing_codes();
    write_register(REG_MODE,     32'h0000_0003);
    write_register(REG_TRG_MISS, 32'h0000_0000);
    write_register(REG_SRC_MISS, 32'h7FFF_FFFF);
    send_item(12'd2, 32'h0000_0000, 32'h0000_0005);     // target missing
    send_item(12'd2, 32'h0000_0005, 32'h7FFF_FFFF);     // source missing
    send_item(12'd2, 32'h8000_0000, 32'h8000_0000);     // old code now plain data
    send_item(12'd2, 32'h7FFF_FFFF, 32'h8000_0000);     // widest difference
    send_item(12'd2, 32'h8000_0000, 32'h7FFF_FFFE);
    send_item(12'd2, 32'hFFFF_FFFF, 32'h0000_0000);     // one step down, reaches zero
  endtask

  // fill one cell until it pins at the store maximum, in both modes
  task automatic test_saturation();
    write_register(REG_MODE,     32'h0000_0001);
    write_register(REG_TRG_MISS, MISSING_DEF);
    write_register(REG_SRC_MISS, MISSING_DEF);
    // back to back on one cell exercises the read-modify-write forward
    idle_enable = 1'b0;
    for (int i = 0; i < 130; i++)
      send_item(12'd5, 32'h7FFF_FFFF, 32'h8000_0001);
    idle_enable = 1'b1;
    for (int i = 0; i < 132; i++)
      send_item(12'd5, 32'h7FFF_FFFF, 32'h8000_0001);
    send_item(12'd5, 32'h0000_0000, 32'h0000_0001);     // step down from the top
    send_item(12'd5, 32'h0000_0002, 32'h0000_0000);     // pinned again
    write_register(REG_MODE, 32'h0000_0000);
    for (int i = 0; i < 262; i++)
      send_item(12'd6, 32'h8000_0001, 32'h7FFF_FFFF);
    send_item(12'd6, 32'h7FFF_FFFF, 32'h8000_0001);
  endtask

  // random sample: wide, within plus or minus one in Q16.16, moderate or one of the extremes
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1, 2, 3: return $urandom();
      4, 5:       return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
      6, 7:       return 32'($urandom_range(0, 32'h0100_0000));
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:    return 32'h0 - 32'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  // one phase of random traffic under the current configuration
  task automatic test_random_traffic(int count);
    logic [CELL_W-1:0]   cell_idx;
    logic [SAMPLE_W-1:0] trg;
    logic [SAMPLE_W-1:0] src;
    logic [SAMPLE_W-1:0] hold;
    bit                  rising;
    int                  roll;
    hot_cells[0] = 0;
    hot_cells[1] = CELLS_DEF - 1;
    for (int i = 2; i < 8; i++)
      hot_cells[i] = $urandom_range(0, CELLS_DEF - 1);
    for (int i = 0; i < count; i++) begin
      // stretches with and without idling
      if (i % 100 == 0)
        idle_enable = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 9) < 7)
        cell_idx = CELL_W'(hot_cells[$urandom_range(0, 7)]);
      else
        cell_idx = CELL_W'($urandom());
      trg = random_sample();
      src = random_sample();
      // lean towards filling so the hot cells build real storage
      rising = tracker_cfg.mode_deficit ? ($signed(trg) > $signed(src))
                                        : ($signed(src) > $signed(trg));
      if (!rising && $urandom_range(0, 9) < 3) begin
        hold = trg;
        trg  = src;
        src  = hold;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6)
        trg = tracker_cfg.target_missing_code;
      else if (roll < 12)
        src = tracker_cfg.source_missing_code;
      send_item(cell_idx, trg, src);
    end
    idle_enable = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    tracker_cfg.mode_deficit        = 1'b1;
    tracker_cfg.target_missing_code = MISSING_DEF;
    tracker_cfg.source_missing_code = MISSING_DEF;
    for (int i = 0; i < CELLS_DEF; i++) begin
      running_level[i] = '0;
      peak_level[i]    = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // the clearing pass after reset holds s_tready low; send_item waits it out
    test_deficit_directed();
    test_surplus_directed();
    test_missing_codes();
    test_saturation();

    // random phases over several settings, the extremes among them
    write_register(REG_MODE, 32'h0000_0001);
    test_random_traffic(ITEMS_PER_PHASE);
    write_register(REG_MODE,     32'h0000_0000);
    write_register(REG_TRG_MISS, 32'h7FFF_FFFF);
    write_register(REG_SRC_MISS, 32'h0000_0000);
    test_random_traffic(ITEMS_PER_PHASE);
    write_register(REG_MODE,     $urandom() | 32'h1);
    write_register(REG_TRG_MISS, $urandom());
    write_register(REG_SRC_MISS, 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000);
    test_random_traffic(ITEMS_PER_PHASE);
    write_register(REG_MODE,     $urandom() & 32'hFFFF_FFFE);
    write_register(REG_TRG_MISS, 32'h0000_0000);
    write_register(REG_SRC_MISS, $urandom());
    test_random_traffic(ITEMS_PER_PHASE);

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("sequent_peak_storage_tracker_unit test passed");
    else
      $display("sequent_peak_storage_tracker_unit test failed");
    $finish;
  end

  // overall limit, well beyond the slowest legal run including the clearing pass
  initial begin
    #12_000_000;
    $display("sequent_peak_storage_tracker_unit test failed");
    $finish;
  end

endmodule
